@@ rtl/rrd_pkg.sv @@
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and constants of the round-robin dispatcher.
// ----------------------------------------------------------------------------
package rrd_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int TIME_BITS_DEF     = 16;
  localparam int TICK_W            = 24;
  localparam int QUANTUM_W         = 16;
  localparam int FIELD_W           = 16;
  localparam int PNUM_W            = 5;

  localparam logic [TICK_W-1:0]    TICK_MAX      = '1;
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd2;

  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_DISPATCH = 2'd1;
  localparam logic [1:0] MODE_CLEAR    = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOTHING   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_ZERO_BURST = 2'd3;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ring_ctl_t;

endpackage

@@ rtl/rrd_ptab.sv @@
// ----------------------------------------------------------------------------
// rrd_ptab
// Process table: arrival, burst and remaining ticks, registered read.
// ----------------------------------------------------------------------------
module rrd_ptab import rrd_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF,
  localparam int IW           = $clog2(MAX_PROCESSES)
) (
  input  logic                 clk,
  input  logic                 load_we,
  input  logic                 rem_we,
  input  logic [IW-1:0]        waddr,
  input  logic [TIME_BITS-1:0] warr,
  input  logic [TIME_BITS-1:0] wbur,
  input  logic [TIME_BITS-1:0] wrem,
  input  logic [IW-1:0]        raddr,
  output logic [TIME_BITS-1:0] rarr,
  output logic [TIME_BITS-1:0] rbur,
  output logic [TIME_BITS-1:0] rrem
);

  logic [TIME_BITS-1:0] arr_mem [MAX_PROCESSES];
  logic [TIME_BITS-1:0] bur_mem [MAX_PROCESSES];
  logic [TIME_BITS-1:0] rem_mem [MAX_PROCESSES];

  always_ff @(posedge clk) begin
    if (load_we) begin
      arr_mem[waddr] <= warr;
      bur_mem[waddr] <= wbur;
    end
    if (load_we || rem_we) begin
      rem_mem[waddr] <= wrem;
    end
    rarr <= arr_mem[raddr];
    rbur <= bur_mem[raddr];
    rrem <= rem_mem[raddr];
  end

endmodule

@@ rtl/rrd_ring.sv @@
// ----------------------------------------------------------------------------
// rrd_ring
// Ready ring of process indices; head entry read through a register.
// ----------------------------------------------------------------------------
module rrd_ring import rrd_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  localparam int IW           = $clog2(MAX_PROCESSES),
  localparam int CW           = $clog2(MAX_PROCESSES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ring_ctl_t     ctl,
  input  logic [IW-1:0] push_idx,
  output logic [IW-1:0] head_idx,
  output logic [CW-1:0] count
);

  localparam logic [IW-1:0] LAST = IW'(MAX_PROCESSES - 1);

  logic [IW-1:0] ring_mem [MAX_PROCESSES];
  logic [IW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (ctl.push) begin
        tail_r <= (tail_r == LAST) ? '0 : tail_r + 1'b1;
      end
      if (ctl.pop) begin
        head_r <= (head_r == LAST) ? '0 : head_r + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        count_r <= count_r + 1'b1;
      end else if (ctl.pop && !ctl.push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ring_mem[tail_r] <= push_idx;
    end
    head_idx <= ring_mem[head_r];
  end

  assign count = count_r;

endmodule

@@ rtl/round_robin_dispatcher.sv @@
// ----------------------------------------------------------------------------
// round_robin_dispatcher
// Round-robin process scheduler over a process table and a ready ring.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  input     in_mode, in_arrival_time, in_burst_time start & !busy
//  result    out_*                                   out_valid, one cycle
//  config    cfg_wr_data                             cfg_wr_en
//
// Load, clear: busy stays low; an error result follows in the next cycle.
// Dispatch: busy through an arrival scan over the loaded processes after
// each slice, one more scan on the first dispatch, and a scan for the
// earliest arrival plus another arrival scan when the ring is empty with
// processes left. The scans are set by the single read port of the process
// table. Reset is synchronous; no clearing pass. Results cannot be stalled.
// ----------------------------------------------------------------------------
module round_robin_dispatcher import rrd_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int TIME_BITS     = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_mode,
  input  logic [FIELD_W-1:0]   in_arrival_time,
  input  logic [FIELD_W-1:0]   in_burst_time,
  input  logic                 cfg_wr_en,
  input  logic [QUANTUM_W-1:0] cfg_wr_data,
  output logic                 out_valid,
  output logic [PNUM_W-1:0]    out_process_number,
  output logic [TICK_W-1:0]    out_slice_start,
  output logic [TICK_W-1:0]    out_slice_end,
  output logic                 out_finished,
  output logic [TICK_W-1:0]    out_turnaround,
  output logic [TICK_W-1:0]    out_waiting,
  output logic                 out_all_done,
  output logic [1:0]           out_status
);

  localparam int IW = $clog2(MAX_PROCESSES);
  localparam int CW = $clog2(MAX_PROCESSES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_PROCESSES);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_IDLECHK, S_MINSET, S_EMPTYCHK, S_POP, S_RUN, S_FIN, S_OUT
  } state_t;

  state_t state_r, ret_r;

  logic [QUANTUM_W-1:0] quantum_r;
  logic [MAX_PROCESSES-1:0] marks_r;
  logic [CW-1:0] loaded_r, completed_r, scan_cnt_r;
  logic [TICK_W-1:0] tick_r, start_tick_r, tat_r;
  logic started_r, scan_min_r, pend_r, found_r, fin_r;
  logic [IW-1:0] pend_idx_r, idx_r;
  logic [TIME_BITS-1:0] earliest_r, arr_r, bur_r, newrem_r;

  logic [TIME_BITS-1:0] arr_in, bur_in, rarr, rbur, rrem;
  logic [IW-1:0] ring_head, prd_addr, pwaddr, push_idx;
  logic [CW-1:0] ring_count;
  ring_ctl_t ring_ctl;
  logic load_we, rem_we, scan_hit;

  logic [31:0] q32, rem32, slice32, tat32, wt32;
  logic [TICK_W:0] tick_sum, tgt;

  assign arr_in = TIME_BITS'(32'(in_arrival_time));
  assign bur_in = TIME_BITS'(32'(in_burst_time));
  assign busy   = (state_r != S_IDLE);

  // arrival check of the entry read in the previous scan cycle
  assign scan_hit = pend_r && !scan_min_r && !marks_r[pend_idx_r] &&
                    (32'(rarr) <= 32'(tick_r));

  always_comb begin
    q32      = (quantum_r == '0) ? 32'd1 : 32'(quantum_r);
    rem32    = 32'(rrem);
    slice32  = (rem32 < q32) ? rem32 : q32;
    tick_sum = {1'b0, tick_r} + (TICK_W+1)'(slice32);
    tgt      = {1'b0, tick_r} + 1'b1;
    if ((TICK_W+1)'(32'(earliest_r)) > tgt) begin
      tgt = (TICK_W+1)'(32'(earliest_r));
    end
    tat32 = (32'(tick_r) >= 32'(arr_r)) ? 32'(tick_r) - 32'(arr_r) : 32'd0;
    wt32  = (32'(tat_r) >= 32'(bur_r)) ? 32'(tat_r) - 32'(bur_r) : 32'd0;
  end

  always_comb begin
    ring_ctl = '0;
    push_idx = pend_idx_r;
    load_we  = 1'b0;
    rem_we   = 1'b0;
    pwaddr   = idx_r;
    prd_addr = (state_r == S_SCAN) ? scan_cnt_r[IW-1:0] : ring_head;
    case (state_r)
      S_IDLE: begin
        pwaddr = loaded_r[IW-1:0];
        if (start) begin
          ring_ctl.clear = (in_mode == MODE_CLEAR);
          load_we = (in_mode == MODE_LOAD) && (bur_in != '0) &&
                    (loaded_r != FULL_CNT);
        end
      end
      S_SCAN: ring_ctl.push = scan_hit;
      S_POP:  ring_ctl.pop = 1'b1;
      S_RUN:  rem_we = 1'b1;
      S_FIN: begin
        push_idx      = idx_r;
        ring_ctl.push = (newrem_r != '0);
      end
      default: ;
    endcase
  end

  rrd_ptab #(.MAX_PROCESSES(MAX_PROCESSES), .TIME_BITS(TIME_BITS)) u_ptab (
    .clk     (clk),
    .load_we (load_we),
    .rem_we  (rem_we),
    .waddr   (pwaddr),
    .warr    (arr_in),
    .wbur    (bur_in),
    .wrem    (load_we ? bur_in : TIME_BITS'(rem32 - slice32)),
    .raddr   (prd_addr),
    .rarr    (rarr),
    .rbur    (rbur),
    .rrem    (rrem)
  );

  rrd_ring #(.MAX_PROCESSES(MAX_PROCESSES)) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ring_ctl),
    .push_idx (push_idx),
    .head_idx (ring_head),
    .count    (ring_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RESET;
    end else if (cfg_wr_en) begin
      quantum_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      marks_r     <= '0;
      loaded_r    <= '0;
      completed_r <= '0;
      tick_r      <= '0;
      started_r   <= 1'b0;
      scan_min_r  <= 1'b0;
      pend_r      <= 1'b0;
      scan_cnt_r  <= '0;
      found_r     <= 1'b0;
      fin_r       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            out_process_number <= '0;
            out_slice_start    <= '0;
            out_slice_end      <= '0;
            out_finished       <= 1'b0;
            out_turnaround     <= '0;
            out_waiting        <= '0;
            out_all_done       <= 1'b0;
            case (in_mode)
              MODE_CLEAR: begin
                marks_r     <= '0;
                loaded_r    <= '0;
                completed_r <= '0;
                tick_r      <= '0;
                started_r   <= 1'b0;
              end
              MODE_LOAD: begin
                if (bur_in == '0) begin
                  out_valid  <= 1'b1;
                  out_status <= ST_ZERO_BURST;
                end else if (loaded_r == FULL_CNT) begin
                  out_valid  <= 1'b1;
                  out_status <= ST_FULL;
                end else begin
                  loaded_r <= loaded_r + 1'b1;
                end
              end
              MODE_DISPATCH: begin
                fin_r <= 1'b0;
                if (!started_r) begin
                  started_r  <= 1'b1;
                  state_r    <= S_SCAN;
                  ret_r      <= S_IDLECHK;
                  scan_min_r <= 1'b0;
                  scan_cnt_r <= '0;
                  pend_r     <= 1'b0;
                end else begin
                  state_r <= S_IDLECHK;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_cnt_r < loaded_r) begin
            pend_r     <= 1'b1;
            pend_idx_r <= scan_cnt_r[IW-1:0];
            scan_cnt_r <= scan_cnt_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) begin
              state_r <= ret_r;
            end
          end
          if (scan_hit) begin
            marks_r[pend_idx_r] <= 1'b1;
          end
          // earliest arrival among never-queued processes
          if (pend_r && scan_min_r && !marks_r[pend_idx_r] &&
              (!found_r || rarr < earliest_r)) begin
            earliest_r <= rarr;
            found_r    <= 1'b1;
          end
        end
        S_IDLECHK: begin
          if (ring_count == '0 && completed_r < loaded_r) begin
            state_r    <= S_SCAN;
            ret_r      <= S_MINSET;
            scan_min_r <= 1'b1;
            scan_cnt_r <= '0;
            pend_r     <= 1'b0;
            found_r    <= 1'b0;
          end else begin
            state_r <= S_EMPTYCHK;
          end
        end
        S_MINSET: begin
          if (found_r) begin
            tick_r     <= tgt[TICK_W] ? TICK_MAX : tgt[TICK_W-1:0];
            state_r    <= S_SCAN;
            ret_r      <= S_EMPTYCHK;
            scan_min_r <= 1'b0;
            scan_cnt_r <= '0;
            pend_r     <= 1'b0;
          end else begin
            state_r <= S_EMPTYCHK;
          end
        end
        S_EMPTYCHK: begin
          if (ring_count == '0) begin
            out_valid          <= 1'b1;
            out_status         <= ST_NOTHING;
            out_all_done       <= (completed_r == loaded_r);
            out_process_number <= '0;
            out_slice_start    <= '0;
            out_slice_end      <= '0;
            out_finished       <= 1'b0;
            out_turnaround     <= '0;
            out_waiting        <= '0;
            state_r            <= S_IDLE;
          end else begin
            state_r <= S_POP;
          end
        end
        S_POP: begin
          idx_r   <= ring_head;
          state_r <= S_RUN;
        end
        S_RUN: begin
          arr_r        <= rarr;
          bur_r        <= rbur;
          newrem_r     <= TIME_BITS'(rem32 - slice32);
          start_tick_r <= tick_r;
          tick_r       <= tick_sum[TICK_W] ? TICK_MAX : tick_sum[TICK_W-1:0];
          state_r      <= S_SCAN;
          ret_r        <= S_FIN;
          scan_min_r   <= 1'b0;
          scan_cnt_r   <= '0;
          pend_r       <= 1'b0;
        end
        S_FIN: begin
          if (newrem_r == '0) begin
            fin_r       <= 1'b1;
            tat_r       <= TICK_W'(tat32);
            completed_r <= completed_r + 1'b1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid          <= 1'b1;
          out_status         <= ST_OK;
          out_process_number <= PNUM_W'(32'(idx_r) + 32'd1);
          out_slice_start    <= start_tick_r;
          out_slice_end      <= tick_r;
          out_finished       <= fin_r;
          out_turnaround     <= fin_r ? tat_r : '0;
          out_waiting        <= fin_r ? TICK_W'(wt32) : '0;
          out_all_done       <= (completed_r == loaded_r);
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
